[rtl/core/integer_to_ascii_radix_top_defines.svh]
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_top_defines
// Assertion macros shared by the checker of the radix text converter.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_TOP_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_TOP_DEFINES_SVH

// same-cycle implication, masked during reset
`define ITAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define ITAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/itar_pkg.sv]
// ----------------------------------------------------------------------------
// itar_pkg
// Types, character constants and digit helpers of the radix text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itar_pkg;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LETTER = 8'h57;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [4:0] DECIMAL   = 5'd10;
  localparam logic [4:0] BASE_MIN  = 5'd2;
  localparam logic [4:0] BASE_MAX  = 5'd16;
  localparam int         STEP_BITS = 8;

  typedef struct packed {
    logic       neg;
    logic [4:0] base;
  } ctrl_t;

  typedef struct packed {
    logic [3:0]           rem;
    logic [STEP_BITS-1:0] quo;
  } div_res_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SIGN = 5'b00010,
    S_DIV  = 5'b00100,
    S_RD   = 5'b01000,
    S_WR   = 5'b10000
  } back_state_t;

  // eight restoring division steps; remainder stays below base
  function automatic div_res_t div_step(input logic [3:0] rem_in,
                                        input logic [STEP_BITS-1:0] bits,
                                        input logic [4:0] base);
    div_res_t res;
    logic [4:0] t;
    logic [3:0] r;
    r = rem_in;
    res.quo = '0;
    for (int k = STEP_BITS - 1; k >= 0; k--) begin
      t = {r, bits[k]};
      if (t >= base) begin
        res.quo[k] = 1'b1;
        r = 4'(t - base);
      end else begin
        r = t[3:0];
      end
    end
    res.rem = r;
    return res;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return ({1'b0, d} < DECIMAL) ? CH_ZERO + 8'(d) : CH_LETTER + 8'(d);
  endfunction

endpackage

`default_nettype wire

[rtl/core/integer_to_ascii_radix_top.sv]
// Flow: the digit engine takes a number from the command queue while it is idle;
// each digit is then found by division of the whole number, eight bits per
// step, and each character by a stack read (S_RD) and an output load (S_WR).
// The digit engine holds one number at a time and takes no new number before it
// is through with the last; two numbers may wait in the queue.
// Reset (rst, synchronous) empties the queue and the output register.
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_top
// Converts a number to ASCII text in base 2..16 or signed decimal.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_radix_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic                   func,
  input  wire logic [VALUE_WIDTH-1:0] value,
  input  wire logic [4:0]             base,
  output logic                        empty,
  input  wire logic                   pop,
  output logic      [7:0]             char_code,
  output logic                        last
);

  localparam int CW = $bits(itar_pkg::ctrl_t);
  localparam int DW = CW + VALUE_WIDTH;

  itar_pkg::ctrl_t        f_ctrl;
  logic [VALUE_WIDTH-1:0] f_mag;
  logic [DW-1:0]          q_rdata;
  logic                   q_valid;
  logic                   q_pop;

  itar_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .func  (func),
    .value (value),
    .base  (base),
    .ctrl  (f_ctrl),
    .mag   (f_mag)
  );

  itar_queue #(
    .DW (DW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({f_ctrl, f_mag}),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  itar_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ctrl  (itar_pkg::ctrl_t'(q_rdata[DW-1:VALUE_WIDTH])),
    .cmd_mag   (q_rdata[VALUE_WIDTH-1:0]),
    .cmd_pop   (q_pop),
    .char_code (char_code),
    .last      (last),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire

[rtl/core/itar_ram.sv]
// ----------------------------------------------------------------------------
// itar_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module itar_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/itar_front.sv]
// ----------------------------------------------------------------------------
// itar_front
// Classifies an incoming number: clamps the base, picks sign and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module itar_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   func,
  input  wire logic [VALUE_WIDTH-1:0] value,
  input  wire logic [4:0]             base,
  output itar_pkg::ctrl_t             ctrl,
  output logic      [VALUE_WIDTH-1:0] mag
);

  always_comb begin
    ctrl = '0;
    mag  = value;
    if (func) begin
      ctrl.base = itar_pkg::DECIMAL;
      ctrl.neg  = value[VALUE_WIDTH-1];
      if (value[VALUE_WIDTH-1]) begin
        mag = VALUE_WIDTH'(0) - value;
      end
    end else if (base < itar_pkg::BASE_MIN) begin
      ctrl.base = itar_pkg::BASE_MIN;
    end else if (base > itar_pkg::BASE_MAX) begin
      ctrl.base = itar_pkg::BASE_MAX;
    end else begin
      ctrl.base = base;
    end
  end

endmodule

`default_nettype wire

[rtl/core/itar_queue.sv]
// ----------------------------------------------------------------------------
// itar_queue
// Two-entry command queue between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module itar_queue #(
  parameter int DW = 38
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [DW-1:0] wdata,
  output logic               full,
  input  wire logic          pop,
  output logic      [DW-1:0] rdata,
  output logic               valid
);

  logic [DW-1:0] mem [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    cnt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt == 2'd2);
  assign valid   = (cnt != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/itar_back.sv]
// ----------------------------------------------------------------------------
// itar_back
// Digit engine: repeated division by the base, digit stack, character output.
// ----------------------------------------------------------------------------
`default_nettype none

module itar_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cmd_valid,
  input  wire itar_pkg::ctrl_t        cmd_ctrl,
  input  wire logic [VALUE_WIDTH-1:0] cmd_mag,
  output logic                        cmd_pop,
  output logic      [7:0]             char_code,
  output logic                        last,
  output logic                        empty,
  input  wire logic                   pop
);

  localparam int SB    = itar_pkg::STEP_BITS;
  localparam int NSTEP = (VALUE_WIDTH + SB - 1) / SB;
  localparam int PADW  = NSTEP * SB;
  localparam int SCW   = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int AW    = $clog2(VALUE_WIDTH);

  itar_pkg::back_state_t state;
  itar_pkg::div_res_t    div;
  logic [PADW-1:0]       dvd;
  logic [PADW-1:0]       quo_next;
  logic [3:0]            rem;
  logic [SCW-1:0]        cnt;
  logic [AW-1:0]         ndig;
  logic [AW-1:0]         idx;
  logic [4:0]            base_r;
  logic                  out_valid;
  logic                  out_free;
  logic                  digit_done;
  logic [3:0]            ram_rdata;

  assign div        = itar_pkg::div_step(rem, dvd[PADW-1 -: SB], base_r);
  assign quo_next   = (dvd << SB) | PADW'(div.quo);
  assign digit_done = (state == itar_pkg::S_DIV) && (cnt == SCW'(NSTEP - 1));
  assign out_free   = !out_valid || pop;
  assign empty      = !out_valid;
  assign cmd_pop    = (state == itar_pkg::S_IDLE) && cmd_valid;

  itar_ram #(
    .WIDTH (4),
    .DEPTH (VALUE_WIDTH)
  ) u_stack (
    .clk   (clk),
    .we    (digit_done),
    .waddr (ndig),
    .wdata (div.rem),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= itar_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        itar_pkg::S_IDLE: begin
          if (cmd_valid) begin
            dvd    <= PADW'(cmd_mag);
            rem    <= '0;
            cnt    <= '0;
            ndig   <= '0;
            base_r <= cmd_ctrl.base;
            state  <= cmd_ctrl.neg ? itar_pkg::S_SIGN : itar_pkg::S_DIV;
          end
        end
        itar_pkg::S_SIGN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            char_code <= itar_pkg::CH_MINUS;
            last      <= 1'b0;
            state     <= itar_pkg::S_DIV;
          end
        end
        itar_pkg::S_DIV: begin
          dvd <= quo_next;
          if (digit_done) begin
            cnt <= '0;
            rem <= '0;
            if (quo_next == '0 || ndig == AW'(VALUE_WIDTH - 1)) begin
              idx   <= ndig;
              state <= itar_pkg::S_RD;
            end else begin
              ndig <= ndig + 1'b1;
            end
          end else begin
            cnt <= cnt + 1'b1;
            rem <= div.rem;
          end
        end
        itar_pkg::S_RD: begin
          state <= itar_pkg::S_WR;
        end
        itar_pkg::S_WR: begin
          if (out_free) begin
            out_valid <= 1'b1;
            char_code <= itar_pkg::digit_char(ram_rdata);
            last      <= (idx == '0);
            if (idx == '0) begin
              state <= itar_pkg::S_IDLE;
            end else begin
              idx   <= idx - 1'b1;
              state <= itar_pkg::S_RD;
            end
          end
        end
        default: begin
          state <= itar_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/itar_checker.sv]
// ----------------------------------------------------------------------------
// itar_checker
// Port-level checks of the radix text converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_to_ascii_radix_top_defines.svh"

module itar_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] char_code,
  input wire logic       last
);

  logic num_start;
  logic lead_pos;
  logic xfer;
  logic is_digit;
  logic is_letter;

  assign xfer      = pop && !empty;
  assign is_digit  = (char_code >= itar_pkg::CH_ZERO) &&
                     (char_code < itar_pkg::CH_ZERO + 8'(itar_pkg::DECIMAL));
  assign is_letter = (char_code >= itar_pkg::CH_LETTER + 8'(itar_pkg::DECIMAL)) &&
                     (char_code < itar_pkg::CH_LETTER + 8'(itar_pkg::BASE_MAX));

  // num_start: next char opens a number; lead_pos: next char is the first digit
  always_ff @(posedge clk) begin
    if (rst) begin
      num_start <= 1'b1;
      lead_pos  <= 1'b1;
    end else if (xfer) begin
      num_start <= last;
      lead_pos  <= last || (char_code == itar_pkg::CH_MINUS);
    end
  end

  `ITAR_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(char_code) && $stable(last), "stalled result changed")
  `ITAR_ASSERT_NOW(a_charset, !empty, is_digit || is_letter || char_code == itar_pkg::CH_MINUS, "bad character")
  `ITAR_ASSERT_NOW(a_minus, !empty && char_code == itar_pkg::CH_MINUS, num_start && !last, "misplaced minus")
  `ITAR_ASSERT_NOW(a_lead_zero, !empty && lead_pos && char_code == itar_pkg::CH_ZERO, last && num_start, "leading zero")

endmodule

bind integer_to_ascii_radix_top itar_checker u_itar_checker (.*);

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Radix text converter: drives numbers through the push/full side and checks
// every popped character against typed-in text or a local formatter.
// Directed rows cover zero, extremes, clamped bases and signed corner values,
// then random numbers in all bases with random idle gaps on both sides.
// ----------------------------------------------------------------------------

module testbench;

  localparam int VW = 32;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } glyph_t;

  typedef struct {
    logic          func;
    logic [VW-1:0] value;
    logic [4:0]    base;
    string         text;
  } row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          push = 1'b0;
  logic          full;
  logic          func = 1'b0;
  logic [VW-1:0] value = '0;
  logic [4:0]    base = '0;
  logic          empty;
  logic          pop = 1'b0;
  logic [7:0]    char_code;
  logic          last;

  glyph_t glyphs_due[$];
  row_t   plan[$];
  int     mismatches = 0;
  int     chars_seen = 0;
  int     numbers_sent = 0;
  int     signed_sent = 0;
  bit     calm = 1'b0;
  int     pop_hold = 0;

  integer_to_ascii_radix_top #(.VALUE_WIDTH(VW)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .value     (value),
    .base      (base),
    .empty     (empty),
    .pop       (pop),
    .char_code (char_code),
    .last      (last)
  );

  always #6 clk = ~clk;

  initial begin
    #20_000_000;
    $display("FAIL integer_to_ascii_radix_top");
    $finish;
  end

  // expected characters of one number
  function automatic void format_number(logic f, logic [VW-1:0] v, logic [4:0] b);
    logic [3:0]    digs[VW];
    logic [VW-1:0] mag;
    logic [4:0]    radix;
    int            nd;
    mag = v;
    radix = b;
    nd = 0;
    if (f) begin
      radix = itar_pkg::DECIMAL;
      if (v[VW-1]) begin
        mag = -v;
        glyphs_due.push_back('{ch: itar_pkg::CH_MINUS, fin: 1'b0});
      end
    end else if (radix < itar_pkg::BASE_MIN) begin
      radix = itar_pkg::BASE_MIN;
    end else if (radix > itar_pkg::BASE_MAX) begin
      radix = itar_pkg::BASE_MAX;
    end
    do begin
      digs[nd] = 4'(mag % radix);
      mag = mag / radix;
      nd++;
    end while (mag != 0 && nd < VW);
    for (int i = nd - 1; i >= 0; i--) begin
      glyphs_due.push_back('{ch: (digs[i] < 4'd10) ? itar_pkg::CH_ZERO + 8'(digs[i])
                                                   : itar_pkg::CH_LETTER + 8'(digs[i]),
                             fin: (i == 0)});
    end
  endfunction

  function automatic void add_row(logic f, logic [VW-1:0] v, logic [4:0] b, string t);
    plan.push_back('{func: f, value: v, base: b, text: t});
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [VW-1:0] rand_value();
    int k;
    k = $urandom_range(0, VW - 1);
    case ($urandom_range(0, 5))
      0: return VW'($urandom_range(0, 20));
      1: return VW'($urandom);
      2: return VW'(1) << k;
      3: return (VW'(1) << k) - 1'b1;
      4: return ~VW'($urandom_range(0, 20));
      default: return {1'b1, (VW-1)'($urandom)};
    endcase
  endfunction

  function automatic logic [4:0] rand_base();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 5'($urandom_range(2, 16));
    if (r < 90) return 5'($urandom_range(0, 1));
    return 5'($urandom_range(17, 31));
  endfunction

  // one number; expected text is typed in or comes from the formatter
  task automatic send_number(logic f, logic [VW-1:0] v, logic [4:0] b, string t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push  <= 1'b1;
    func  <= f;
    value <= v;
    base  <= b;
    do @(posedge clk); while (full);
    if (t.len() > 0) begin
      for (int i = 0; i < t.len(); i++)
        glyphs_due.push_back('{ch: t[i], fin: (i == t.len() - 1)});
    end else begin
      format_number(f, v, b);
    end
    numbers_sent++;
    if (f) signed_sent++;
  endtask

  // result side stalls
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else if (calm || r < 70) begin
      pop <= 1'b1;
    end else begin
      pop <= 1'b0;
      pop_hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 60);
    end
  end

  always @(posedge clk) begin
    glyph_t want;
    if (!rst && pop && !empty) begin
      chars_seen++;
      if (glyphs_due.size() == 0) begin
        $display("%0t: unexpected transfer char_code=%h last=%b", $time, char_code, last);
        mismatches++;
      end else begin
        want = glyphs_due.pop_front();
        if (char_code !== want.ch) begin
          $display("%0t: char_code expected %h actual %h", $time, want.ch, char_code);
          mismatches++;
        end
        if (last !== want.fin) begin
          $display("%0t: last expected %b actual %b", $time, want.fin, last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    add_row(1'b0, 32'd0,          5'd10, "0");
    add_row(1'b0, 32'd0,          5'd2,  "0");
    add_row(1'b0, 32'hFFFF_FFFF,  5'd16, "ffffffff");
    add_row(1'b0, 32'hFFFF_FFFF,  5'd10, "4294967295");
    add_row(1'b0, 32'hFFFF_FFFF,  5'd8,  "37777777777");
    add_row(1'b0, 32'hFFFF_FFFF,  5'd2,  "");
    add_row(1'b0, 32'hFFFF_FFFF,  5'd0,  "");
    add_row(1'b0, 32'd5,          5'd1,  "101");
    add_row(1'b0, 32'd255,        5'd17, "ff");
    add_row(1'b0, 32'hFFFF_FFFF,  5'd31, "ffffffff");
    add_row(1'b0, 32'hDEAD_BEEF,  5'd16, "deadbeef");
    add_row(1'b0, 32'd9,          5'd10, "9");
    add_row(1'b0, 32'd10,         5'd16, "a");
    add_row(1'b0, 32'd15,         5'd16, "f");
    add_row(1'b0, 32'h8000_0000,  5'd2,  "");
    add_row(1'b0, 32'h1234_5678,  5'd3,  "");
    add_row(1'b0, 32'hCAFE_F00D,  5'd13, "");
    add_row(1'b1, 32'h8000_0000,  5'd0,  "-2147483648");
    add_row(1'b1, 32'h7FFF_FFFF,  5'd10, "2147483647");
    add_row(1'b1, 32'hFFFF_FFFF,  5'd10, "-1");
    add_row(1'b1, 32'd0,          5'd31, "0");
    add_row(1'b1, 32'd12345,      5'd3,  "12345");
    add_row(1'b1, 32'hFFFF_FFF6,  5'd16, "-10");

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (plan[i])
      send_number(plan[i].func, plan[i].value, plan[i].base, plan[i].text);

    for (int n = 0; n < 87; n++) begin
      calm = (n >= 20 && n < 40);
      if (n == 60) begin
        @(negedge clk) push <= 1'b0;
        while (glyphs_due.size() != 0) @(posedge clk);
      end
      send_number($urandom_range(0, 2) == 0, rand_value(), rand_base(), "");
    end
    @(negedge clk) push <= 1'b0;

    while (glyphs_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("covered %0d numbers (%0d signed decimal), %0d characters checked",
             numbers_sent, signed_sent, chars_seen);
    if (mismatches == 0 && glyphs_due.size() == 0) begin
      $display("PASS integer_to_ascii_radix_top");
    end else begin
      $display("FAIL integer_to_ascii_radix_top");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/itar_pkg.sv
rtl/core/itar_ram.sv
rtl/core/itar_front.sv
rtl/core/itar_queue.sv
rtl/core/itar_back.sv
rtl/core/integer_to_ascii_radix_top.sv
rtl/core/itar_checker.sv
tb/testbench.sv
